@@ sv/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list: action and status
// codes, the cell command set and the command word broadcast along the row.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int PAL_DEPTH_DEF = 128;
    localparam int PAL_DEPTH_MAX = 1024;
    localparam int PAL_IDX_W     = $clog2(PAL_DEPTH_MAX + 1);
    localparam int PAL_DATA_W    = 32;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_LOAD   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_CAPTURE,
        CELL_HIT_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [PAL_IDX_W-1:0]  idx;
        logic [PAL_IDX_W-1:0]  limit;
        logic [PAL_DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

@@ sv/pal_cell.sv @@
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds one entry and one match flag, and takes data from the
// neighbor above or below as the broadcast command says.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                           aclk,
    input  pal_pkg::cell_cmd_t             cmd,
    input  logic [pal_pkg::PAL_DATA_W-1:0] below_entry,
    input  logic [pal_pkg::PAL_DATA_W-1:0] above_entry,
    input  logic                           above_hit,
    output logic [pal_pkg::PAL_DATA_W-1:0] entry,
    output logic                           hit
);
    import pal_pkg::*;

    localparam logic [PAL_IDX_W-1:0] MY_IDX = PAL_IDX_W'(CELL_INDEX);

    logic [PAL_DATA_W-1:0] entry_reg;
    logic                  hit_reg;

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            CELL_HOLD: begin
            end
            CELL_WRITE: begin
                if (cmd.idx == MY_IDX) begin
                    entry_reg <= cmd.data;
                end
            end
            CELL_SHIFT_UP: begin
                if (MY_IDX > cmd.idx && MY_IDX <= cmd.limit) begin
                    entry_reg <= below_entry;
                end else if (MY_IDX == cmd.idx) begin
                    entry_reg <= cmd.data;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (MY_IDX >= cmd.idx && (MY_IDX + PAL_IDX_W'(1)) < cmd.limit) begin
                    entry_reg <= above_entry;
                end
            end
            CELL_CAPTURE: begin
                hit_reg <= (entry_reg == cmd.data) && (MY_IDX < cmd.limit);
            end
            CELL_HIT_SHIFT: begin
                hit_reg <= above_hit;
            end
            default: begin
            end
        endcase
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ sv/pal_chain.sv @@
// ----------------------------------------------------------------------------
// pal_chain
// Row of DEPTH list cells; neighbors are wired for shift up, shift down and
// the match flag scan toward slot zero.
// ----------------------------------------------------------------------------
module pal_chain #(
    parameter int DEPTH = pal_pkg::PAL_DEPTH_DEF
) (
    input  logic               aclk,
    input  pal_pkg::cell_cmd_t cmd,
    output logic               hit_first
);
    import pal_pkg::*;

    logic [PAL_DATA_W-1:0] entry_w [DEPTH];
    logic                  hit_w   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [PAL_DATA_W-1:0] below_w;
        logic [PAL_DATA_W-1:0] above_w;
        logic                  above_hit_w;

        if (i == 0) begin : g_first
            assign below_w = '0;
        end else begin : g_mid_lo
            assign below_w = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign above_w     = '0;
            assign above_hit_w = 1'b0;
        end else begin : g_mid_hi
            assign above_w     = entry_w[i+1];
            assign above_hit_w = hit_w[i+1];
        end

        pal_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .below_entry(below_w),
            .above_entry(above_w),
            .above_hit  (above_hit_w),
            .entry      (entry_w[i]),
            .hit        (hit_w[i])
        );
    end

    assign hit_first = hit_w[0];

endmodule

@@ sv/positional_array_list.sv @@
// ----------------------------------------------------------------------------
// positional_array_list
// Dense list of up to DEPTH 32-bit values with insert, update and load by
// 1-based position, search and remove by value, one result per item.
// ----------------------------------------------------------------------------
// Insert, update, load and unknown actions complete in the cycle of the input
// transfer, so these items run at one per cycle while the output register is
// free. Search and remove first capture a match flag in every cell, then shift
// the flags toward slot zero one position per cycle until the first match
// reaches slot zero, or report a miss once the scan passes the element count.
// A result that cannot leave waits in a holding register; no new item is taken
// until it has moved into the output register.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int DEPTH = pal_pkg::PAL_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic signed [31:0] s_value,
    input  logic [7:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_found_position,
    output logic [7:0]  m_element_count
);
    import pal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = ((CW > 8) ? CW : 8) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            rem_reg, rem_next;
    logic            m_valid_reg;
    status_t         m_status_reg;
    logic [7:0]      m_found_reg;
    logic [7:0]      m_count_reg;
    status_t         res_status_reg;
    logic [7:0]      res_found_reg;
    logic [7:0]      res_count_reg;

    cell_cmd_t       cmd;
    logic            hit_first;
    logic            emit;
    logic            out_free;
    status_t         r_status;
    logic [7:0]      r_found;
    logic [KW-1:0]   pos_k;
    logic [KW-1:0]   cnt_k;

    pal_chain #(
        .DEPTH(DEPTH)
    ) u_chain (
        .aclk     (aclk),
        .cmd      (cmd),
        .hit_first(hit_first)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign pos_k    = KW'(s_position);
    assign cnt_k    = KW'(cnt_reg);
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        cmd.op     = CELL_HOLD;
        cmd.idx    = PAL_IDX_W'(pos_k - KW'(1));
        cmd.limit  = PAL_IDX_W'(cnt_reg);
        cmd.data   = s_value;
        emit       = 1'b0;
        r_status   = ST_OK;
        r_found    = '0;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    emit = 1'b1;
                    unique case (s_action)
                        ACT_INSERT: begin
                            if (pos_k == '0 || pos_k > cnt_k + KW'(1)) begin
                                r_status = ST_BADPOS;
                            end else if (cnt_k == KW'(DEPTH)) begin
                                r_status = ST_FULL;
                            end else begin
                                cmd.op   = CELL_SHIFT_UP;
                                cnt_next = CW'(cnt_k + KW'(1));
                            end
                        end
                        ACT_UPDATE: begin
                            if (pos_k == '0 || pos_k > cnt_k) begin
                                r_status = ST_BADPOS;
                            end else begin
                                cmd.op = CELL_WRITE;
                            end
                        end
                        ACT_SEARCH, ACT_REMOVE: begin
                            emit       = 1'b0;
                            cmd.op     = CELL_CAPTURE;
                            k_next     = '0;
                            rem_next   = (s_action == ACT_REMOVE);
                            state_next = S_SCAN;
                        end
                        ACT_LOAD: begin
                            if (pos_k == '0) begin
                                cnt_next = '0;
                            end else if (pos_k > KW'(DEPTH)) begin
                                r_status = ST_FULL;
                            end else begin
                                cmd.op   = CELL_WRITE;
                                cnt_next = CW'(pos_k);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.op  = CELL_HIT_SHIFT;
                cmd.idx = PAL_IDX_W'(k_reg);
                priority if (hit_first) begin
                    emit    = 1'b1;
                    r_found = 8'(KW'(k_reg) + KW'(1));
                    if (rem_reg) begin
                        cmd.op   = CELL_SHIFT_DOWN;
                        cnt_next = CW'(cnt_k - KW'(1));
                    end
                end else if (k_reg == cnt_reg) begin
                    emit     = 1'b1;
                    r_status = ST_NOTFOUND;
                end else begin
                    k_next = CW'(KW'(k_reg) + KW'(1));
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (emit) begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            rem_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            rem_reg   <= rem_next;
            if (emit && out_free) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= r_status;
                m_found_reg  <= r_found;
                m_count_reg  <= 8'(cnt_next);
            end else if (state_reg == S_HOLD && out_free) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= res_status_reg;
                m_found_reg  <= res_found_reg;
                m_count_reg  <= res_count_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit && !out_free) begin
                res_status_reg <= r_status;
                res_found_reg  <= r_found;
                res_count_reg  <= 8'(cnt_next);
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_element_count  = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        KW'(cnt_reg) <= KW'(DEPTH))
        else $error("element count above depth");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> k_reg <= cnt_reg)
        else $error("scan ran past element count");

    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_HOLD |-> m_valid_reg)
        else $error("held result while output register empty");

    a_count_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) && state_reg != S_SCAN |=> $stable(cnt_reg))
        else $error("element count changed without an operation");

endmodule
